// File: rtl/best_fit_page_allocator_unit_assert.svh
// Assertion macros used by the allocator top module
`ifndef BEST_FIT_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// Check that a condition implies a consequence on the same edge
`define BFPA_ASSERT_IMP(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence on the next edge
`define BFPA_ASSERT_NXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/bfpa_pkg.sv
package bfpa_pkg;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_e;

  localparam logic [0:0] REG_BASE  = 1'b0;
  localparam logic [0:0] REG_PAGES = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] request_bytes;
    logic [63:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] granted_address;
    logic [16:0] heap_size_pages;
    logic [16:0] allocated_pages;
    logic [16:0] avail_pages;
  } rsp_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,      // capture request, compute need / offset
    OP_INIT,       // latch heap geometry, reset counters
    OP_CLR,        // clear one entry of flag memories
    OP_INIT_MARK,  // write whole-heap block
    OP_SCAN_RD,    // read length/use at scan pointer
    OP_SCAN_EVAL,  // evaluate block at scan pointer
    OP_ALLOC_W0,   // write allocated head
    OP_ALLOC_W1,   // write allocated tail
    OP_ALLOC_W2,   // write remainder head
    OP_ALLOC_W3,   // write remainder (or allocated) tail, update counters
    OP_FREE_CHK,   // read head of block to free
    OP_FREE_EVAL,  // validate, read previous page
    OP_FREE_PREV,  // merge with previous free block via its link
    OP_FREE_NXT,   // read next block head
    OP_FREE_NEVAL, // evaluate next block
    OP_FREE_W0,    // clear allocated-start and length
    OP_FREE_W1,    // write merged head
    OP_FREE_W2,    // write merged tail, update counters
    OP_DONE_OK,
    OP_DONE_ERR1,
    OP_DONE_ERR2
  } op_e;

  typedef struct packed {
    logic idx_ok;      // free address aligned and in heap
    logic need_zero;   // allocate of zero bytes
    logic clr_last;    // clearing pass at final entry
    logic scan_end;    // scan pointer left heap or chain broke
    logic found;       // a fitting block was seen
    logic free_bad;    // head of block not allocated / bad length
    logic rem_zero;    // allocation uses whole block
  } stat_t;

endpackage

// File: rtl/best_fit_page_allocator_unit.sv
// Best-fit page allocator. Raise start with a command while busy is low;
// exactly one result follows, shown for one cycle with done_o high, and the
// receiver cannot stall it. Init clears the page flag memories one entry a
// cycle. Allocate walks the block chain. Free ends early when the address
// is rejected. Each page-table memory has a single read port.
`include "best_fit_page_allocator_unit_assert.svh"

module best_fit_page_allocator_unit #(
  parameter int MAX_PAGES      = 65536,
  parameter int PAGE_SIZE_LOG2 = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bfpa_pkg::req_t  req_i,
  output logic            done_o,
  output bfpa_pkg::rsp_t  rsp_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output logic            pready
);
  logic [63:0] base_q;
  logic [16:0] pages_q;
  logic        wr_en;
  logic        sel_reg;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign sel_reg = paddr[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pages_q <= '0;
    end else if (wr_en && paddr[2:0] == 3'd0 && paddr[3] == bfpa_pkg::REG_BASE) begin
      base_q <= pwdata;
    end else if (wr_en && paddr[2:0] == 3'd0 && sel_reg == bfpa_pkg::REG_PAGES) begin
      pages_q <= pwdata[16:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_reg == bfpa_pkg::REG_BASE) prdata = base_q;
    else prdata = {47'd0, pages_q};
  end

  bfpa_pkg::op_e   op;
  bfpa_pkg::stat_t stat;

  bfpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .command_i(req_i.command),
    .stat_i(stat), .op_o(op), .busy_o(busy));

  bfpa_dp #(.MaxPages(MAX_PAGES), .PageSizeLog2(PAGE_SIZE_LOG2)) u_dp (
    .clk_i, .rst_ni, .op_i(op), .req_i(req_i), .cfg_base_i(base_q),
    .cfg_pages_i(pages_q), .stat_o(stat), .rsp_valid_o(done_o), .rsp_o(rsp_o));

  `BFPA_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `BFPA_ASSERT_IMP(a_done_counts, clk_i, rst_ni, done_o,
    rsp_o.allocated_pages + rsp_o.avail_pages == rsp_o.heap_size_pages)
  `BFPA_ASSERT_IMP(a_grant_ok, clk_i, rst_ni, done_o && rsp_o.status != bfpa_pkg::ST_OK,
    rsp_o.granted_address == 64'd0)
endmodule

// File: rtl/bfpa_ram.sv
module bfpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/bfpa_ctrl.sv
module bfpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        command_i,
  input  bfpa_pkg::stat_t   stat_i,
  output bfpa_pkg::op_e     op_o,
  output logic              busy_o
);
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_LATCH  = 14'b00000000000010,
    S_CLR    = 14'b00000000000100,
    S_IMARK  = 14'b00000000001000,
    S_SRD    = 14'b00000000010000,
    S_SEVAL  = 14'b00000000100000,
    S_AW     = 14'b00000001000000,
    S_FCHK   = 14'b00000010000000,
    S_FEVAL  = 14'b00000100000000,
    S_FPREV  = 14'b00001000000000,
    S_FNXT   = 14'b00010000000000,
    S_FNEVAL = 14'b00100000000000,
    S_FW     = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] sub_q, sub_d;
  logic [1:0] cmd_q, cmd_d;
  bfpa_pkg::op_e done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sub_q   <= '0;
      cmd_q   <= '0;
      done_q  <= bfpa_pkg::OP_DONE_OK;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      cmd_q   <= cmd_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    cmd_d   = cmd_q;
    done_d  = done_q;
    op_o    = bfpa_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = command_i;
          op_o    = bfpa_pkg::OP_LATCH;
          state_d = S_LATCH;
        end
      end
      S_LATCH: begin
        sub_d  = '0;
        done_d = bfpa_pkg::OP_DONE_OK;
        case (cmd_q)
          bfpa_pkg::CMD_INIT: begin
            op_o = bfpa_pkg::OP_INIT;
            state_d = S_CLR;
          end
          bfpa_pkg::CMD_ALLOC: begin
            if (stat_i.need_zero) begin
              done_d  = bfpa_pkg::OP_DONE_ERR1;
              state_d = S_DONE;
            end else begin
              state_d = S_SRD;
            end
          end
          bfpa_pkg::CMD_FREE: begin
            if (!stat_i.idx_ok) begin
              done_d  = bfpa_pkg::OP_DONE_ERR2;
              state_d = S_DONE;
            end else begin
              op_o    = bfpa_pkg::OP_FREE_CHK;
              state_d = S_FCHK;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_CLR: begin
        op_o = bfpa_pkg::OP_CLR;
        if (stat_i.clr_last) state_d = S_IMARK;
      end
      S_IMARK: begin
        op_o    = bfpa_pkg::OP_INIT_MARK;
        state_d = S_DONE;
      end
      S_SRD: begin
        if (stat_i.scan_end) begin
          if (stat_i.found) begin
            sub_d   = '0;
            state_d = S_AW;
          end else begin
            done_d  = bfpa_pkg::OP_DONE_ERR1;
            state_d = S_DONE;
          end
        end else begin
          op_o    = bfpa_pkg::OP_SCAN_RD;
          state_d = S_SEVAL;
        end
      end
      S_SEVAL: begin
        op_o    = bfpa_pkg::OP_SCAN_EVAL;
        state_d = S_SRD;
      end
      S_AW: begin
        sub_d = sub_q + 2'd1;
        case (sub_q)
          2'd0: op_o = bfpa_pkg::OP_ALLOC_W0;
          2'd1: begin
            op_o = bfpa_pkg::OP_ALLOC_W1;
            if (stat_i.rem_zero) begin
              op_o    = bfpa_pkg::OP_ALLOC_W3;
              state_d = S_DONE;
            end
          end
          2'd2: op_o = bfpa_pkg::OP_ALLOC_W2;
          default: begin
            op_o    = bfpa_pkg::OP_ALLOC_W3;
            state_d = S_DONE;
          end
        endcase
      end
      S_FCHK: begin
        // wait here so the head entry at the loaded pointer is read
        sub_d = sub_q + 2'd1;
        if (sub_q != 2'd0) begin
          op_o    = bfpa_pkg::OP_FREE_EVAL;
          state_d = S_FEVAL;
        end
      end
      S_FEVAL: begin
        if (stat_i.free_bad) begin
          done_d  = bfpa_pkg::OP_DONE_ERR2;
          state_d = S_DONE;
        end else begin
          op_o    = bfpa_pkg::OP_FREE_PREV;
          state_d = S_FPREV;
        end
      end
      S_FPREV: begin
        op_o    = bfpa_pkg::OP_FREE_NXT;
        state_d = S_FNXT;
      end
      S_FNXT: begin
        op_o    = bfpa_pkg::OP_FREE_NEVAL;
        state_d = S_FNEVAL;
      end
      S_FNEVAL: begin
        op_o    = bfpa_pkg::OP_FREE_W0;
        sub_d   = '0;
        state_d = S_FW;
      end
      S_FW: begin
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd0) begin
          op_o = bfpa_pkg::OP_FREE_W1;
        end else begin
          op_o    = bfpa_pkg::OP_FREE_W2;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        op_o    = done_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// File: rtl/bfpa_dp.sv
module bfpa_dp #(
  parameter int MaxPages     = 65536,
  parameter int PageSizeLog2 = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfpa_pkg::op_e     op_i,
  input  bfpa_pkg::req_t    req_i,
  input  logic [63:0]       cfg_base_i,
  input  logic [16:0]       cfg_pages_i,
  output bfpa_pkg::stat_t   stat_o,
  output logic              rsp_valid_o,
  output bfpa_pkg::rsp_t    rsp_o
);
  localparam int AW = $clog2(MaxPages);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MaxP = CW'(MaxPages);
  localparam logic [63:0] PMask = (64'd1 << PageSizeLog2) - 64'd1;

  // Page counts here are carried in CW bits; results are 17 bits wide.
  logic [63:0]   base_q;
  logic [CW-1:0] npages_q;
  logic [16:0]   alloc_cnt_q, free_cnt_q;
  logic [1:0]    cmd_q;
  logic [CW-1:0] need_q;
  logic          need_zero_q, need_big_q;
  logic [63:0]   off_q;
  logic [CW-1:0] ptr_q;      // scan pointer / free start
  logic          found_q;
  logic [CW-1:0] best_p_q, best_len_q;
  logic [CW-1:0] flen_q, start_q, total_q, nxt_q;
  logic          bad_q;
  logic [CW-1:0] clr_q;
  logic          rsp_valid_q;
  bfpa_pkg::rsp_t rsp_q;

  // Memories
  logic          use_we, ast_we, len_we, lnk_we;
  logic [AW-1:0] use_wa, ast_wa, len_wa, lnk_wa;
  logic          use_wd, ast_wd;
  logic [CW-1:0] len_wd;
  logic [AW-1:0] lnk_wd;
  logic [AW-1:0] use_ra, ast_ra, len_ra, lnk_ra;
  logic          use_rd, ast_rd;
  logic [CW-1:0] len_rd;
  logic [AW-1:0] lnk_rd;

  bfpa_ram #(.Width(1), .Depth(MaxPages)) u_use (
    .clk_i, .we_i(use_we), .waddr_i(use_wa), .wdata_i(use_wd),
    .raddr_i(use_ra), .rdata_o(use_rd));
  bfpa_ram #(.Width(1), .Depth(MaxPages)) u_ast (
    .clk_i, .we_i(ast_we), .waddr_i(ast_wa), .wdata_i(ast_wd),
    .raddr_i(ast_ra), .rdata_o(ast_rd));
  bfpa_ram #(.Width(CW), .Depth(MaxPages)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_wa), .wdata_i(len_wd),
    .raddr_i(len_ra), .rdata_o(len_rd));
  bfpa_ram #(.Width(AW), .Depth(MaxPages)) u_lnk (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_wa), .wdata_i(lnk_wd),
    .raddr_i(lnk_ra), .rdata_o(lnk_rd));

  // Request decode
  logic [32:0] bytes_rnd;
  logic [32:0] need_full;
  logic [63:0] off_c;
  logic [63:0] idx_c;
  logic [17:0] cfg_clip;
  assign bytes_rnd = {1'b0, req_i.request_bytes} + 33'(PMask);
  assign need_full = bytes_rnd >> PageSizeLog2;
  assign off_c     = req_i.block_address - base_q;
  assign idx_c     = off_q >> PageSizeLog2;
  assign cfg_clip  = ({1'b0, cfg_pages_i} > 18'(MaxPages)) ? 18'(MaxPages)
                                                           : {1'b0, cfg_pages_i};

  logic idx_ok;
  assign idx_ok = ((off_q & PMask) == 64'd0) && (idx_c < 64'(npages_q));

  // Scan evaluation
  logic [CW:0] scan_sum;
  logic        scan_break;
  assign scan_sum   = {1'b0, ptr_q} + {1'b0, len_rd};
  assign scan_break = (len_rd == '0) || (scan_sum > {1'b0, npages_q});

  logic [CW-1:0] rem_len;
  assign rem_len = best_len_q - need_q;

  logic [CW:0] f_end;
  assign f_end = {1'b0, ptr_q} + {1'b0, len_rd};
  logic [CW:0] n_end;
  assign n_end = {1'b0, nxt_q} + {1'b0, len_rd};

  always_comb begin
    stat_o.idx_ok    = idx_ok;
    stat_o.need_zero = need_zero_q;
    stat_o.clr_last  = (clr_q == MaxP - CW'(1));
    stat_o.scan_end  = (ptr_q >= npages_q);
    stat_o.found     = found_q;
    stat_o.free_bad  = bad_q;
    stat_o.rem_zero  = (rem_len == '0);
  end

  // Memory port control
  always_comb begin
    use_we = 1'b0; ast_we = 1'b0; len_we = 1'b0; lnk_we = 1'b0;
    use_wa = ptr_q[AW-1:0]; ast_wa = ptr_q[AW-1:0];
    len_wa = ptr_q[AW-1:0]; lnk_wa = ptr_q[AW-1:0];
    use_wd = 1'b0; ast_wd = 1'b0; len_wd = '0; lnk_wd = '0;
    use_ra = ptr_q[AW-1:0]; ast_ra = ptr_q[AW-1:0];
    len_ra = ptr_q[AW-1:0]; lnk_ra = ptr_q[AW-1:0];
    case (op_i)
      bfpa_pkg::OP_CLR: begin
        use_we = 1'b1; ast_we = 1'b1;
        use_wa = clr_q[AW-1:0]; ast_wa = clr_q[AW-1:0];
      end
      bfpa_pkg::OP_INIT_MARK: begin
        if (npages_q != '0) begin
          len_we = 1'b1; len_wa = '0; len_wd = npages_q;
          lnk_we = 1'b1; lnk_wa = AW'(npages_q - CW'(1)); lnk_wd = '0;
        end
      end
      bfpa_pkg::OP_ALLOC_W0: begin
        len_we = 1'b1; len_wa = best_p_q[AW-1:0]; len_wd = need_q;
        use_we = 1'b1; use_wa = best_p_q[AW-1:0]; use_wd = 1'b1;
        ast_we = 1'b1; ast_wa = best_p_q[AW-1:0]; ast_wd = 1'b1;
      end
      bfpa_pkg::OP_ALLOC_W1, bfpa_pkg::OP_ALLOC_W3: begin
        if (op_i == bfpa_pkg::OP_ALLOC_W1 || rem_len == '0) begin
          use_we = 1'b1; use_wa = AW'(best_p_q + need_q - CW'(1)); use_wd = 1'b1;
          lnk_we = 1'b1; lnk_wa = AW'(best_p_q + need_q - CW'(1));
          lnk_wd = best_p_q[AW-1:0];
        end else begin
          use_we = 1'b1; use_wa = AW'(best_p_q + best_len_q - CW'(1));
          lnk_we = 1'b1; lnk_wa = AW'(best_p_q + best_len_q - CW'(1));
          lnk_wd = AW'(best_p_q + need_q);
        end
      end
      bfpa_pkg::OP_ALLOC_W2: begin
        len_we = 1'b1; len_wa = AW'(best_p_q + need_q); len_wd = rem_len;
        use_we = 1'b1; use_wa = AW'(best_p_q + need_q);
      end
      bfpa_pkg::OP_FREE_EVAL: begin
        use_ra = AW'(ptr_q - CW'(1));
        lnk_ra = AW'(ptr_q - CW'(1));
      end
      bfpa_pkg::OP_FREE_NXT: begin
        use_ra = nxt_q[AW-1:0];
        len_ra = nxt_q[AW-1:0];
      end
      bfpa_pkg::OP_FREE_W0: begin
        ast_we = 1'b1; ast_wa = ptr_q[AW-1:0];
        len_we = 1'b1; len_wa = ptr_q[AW-1:0]; len_wd = '0;
      end
      bfpa_pkg::OP_FREE_W1: begin
        len_we = 1'b1; len_wa = start_q[AW-1:0]; len_wd = total_q;
        use_we = 1'b1; use_wa = start_q[AW-1:0];
      end
      bfpa_pkg::OP_FREE_W2: begin
        use_we = 1'b1; use_wa = AW'(start_q + total_q - CW'(1));
        lnk_we = 1'b1; lnk_wa = AW'(start_q + total_q - CW'(1));
        lnk_wd = start_q[AW-1:0];
      end
      default: ;
    endcase
  end

  // Control-free payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      bfpa_pkg::OP_LATCH: begin
        cmd_q       <= req_i.command;
        need_zero_q <= (req_i.request_bytes == 32'd0);
        need_big_q  <= (need_full > 33'(MaxPages));
        need_q      <= (need_full > 33'(MaxPages)) ? MaxP : CW'(need_full);
        off_q       <= off_c;
        ptr_q       <= '0;
        found_q     <= 1'b0;
        best_len_q  <= '0;
        best_p_q    <= '0;
        clr_q       <= '0;
      end
      bfpa_pkg::OP_INIT: clr_q <= '0;
      bfpa_pkg::OP_CLR: clr_q <= clr_q + CW'(1);
      bfpa_pkg::OP_SCAN_EVAL: begin
        if (scan_break) begin
          ptr_q <= npages_q;
        end else begin
          if (!use_rd && !need_big_q && len_rd >= need_q &&
              (!found_q || len_rd < best_len_q)) begin
            found_q    <= 1'b1;
            best_p_q   <= ptr_q;
            best_len_q <= len_rd;
          end
          ptr_q <= CW'(scan_sum);
        end
      end
      bfpa_pkg::OP_FREE_CHK: ptr_q <= CW'(idx_c);
      bfpa_pkg::OP_FREE_EVAL: begin
        bad_q   <= !ast_rd || (len_rd == '0) || (f_end > {1'b0, npages_q});
        flen_q  <= len_rd;
        start_q <= ptr_q;
        total_q <= len_rd;
        nxt_q   <= CW'(f_end);
      end
      bfpa_pkg::OP_FREE_PREV: begin
        if (ptr_q != '0 && !use_rd && {1'b0, lnk_rd} < ptr_q) begin
          start_q <= CW'(lnk_rd);
          total_q <= total_q + (ptr_q - CW'(lnk_rd));
        end
      end
      bfpa_pkg::OP_FREE_NEVAL: begin
        if ((nxt_q < npages_q) && !use_rd && (n_end <= {1'b0, npages_q})) begin
          total_q <= total_q + len_rd;
        end
      end
      default: ;
    endcase
  end

  // FREE_CHK reads at ptr after it is loaded; FREE_EVAL sees that data.
  // Geometry, counters and response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      npages_q    <= '0;
      alloc_cnt_q <= '0;
      free_cnt_q  <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (op_i)
        bfpa_pkg::OP_INIT: begin
          base_q      <= (cfg_base_i + PMask) & ~PMask;
          npages_q    <= CW'(cfg_clip);
          alloc_cnt_q <= '0;
          free_cnt_q  <= 17'(cfg_clip);
        end
        bfpa_pkg::OP_ALLOC_W3: begin
          alloc_cnt_q <= alloc_cnt_q + 17'(need_q);
          free_cnt_q  <= free_cnt_q - 17'(need_q);
        end
        bfpa_pkg::OP_FREE_W2: begin
          alloc_cnt_q <= alloc_cnt_q - 17'(flen_q);
          free_cnt_q  <= free_cnt_q + 17'(flen_q);
        end
        bfpa_pkg::OP_DONE_OK, bfpa_pkg::OP_DONE_ERR1, bfpa_pkg::OP_DONE_ERR2: begin
          rsp_valid_q           <= 1'b1;
          rsp_q.heap_size_pages <= 17'(npages_q);
          rsp_q.allocated_pages <= alloc_cnt_q;
          rsp_q.avail_pages     <= free_cnt_q;
          rsp_q.granted_address <= '0;
          if (op_i == bfpa_pkg::OP_DONE_OK) begin
            rsp_q.status <= bfpa_pkg::ST_OK;
            if (cmd_q == bfpa_pkg::CMD_ALLOC) begin
              rsp_q.granted_address <= base_q + (64'(best_p_q) << PageSizeLog2);
            end
          end else if (op_i == bfpa_pkg::OP_DONE_ERR1) begin
            rsp_q.status <= bfpa_pkg::ST_NO_FIT;
          end else begin
            rsp_q.status <= bfpa_pkg::ST_BAD_ADDR;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
endmodule

// File: tb/sv/best_fit_page_allocator_checker.sv
`timescale 1ns / 100ps

module best_fit_page_allocator_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  bfpa_pkg::req_t  req_i,
  input  logic            done_i,
  input  bfpa_pkg::rsp_t  rsp_i,
  input  logic            psel_i,
  input  logic            penable_i,
  input  logic            pwrite_i,
  input  logic [3:0]      paddr_i,
  input  logic [63:0]     pwdata_i,
  input  logic            pready_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              checked_o
);
  import bfpa_pkg::*;

  localparam int unsigned NPAGES = 65536;
  localparam int PG_LOG2 = 12;

  logic [63:0] base_reg;
  logic [16:0] pages_reg;
  logic [63:0] heap_base;
  int unsigned heap_pages;
  bit          page_used [NPAGES];
  int unsigned blk_len   [NPAGES];
  int unsigned blk_head  [NPAGES];
  bit          alloc_head[NPAGES];
  logic [16:0] pages_taken;
  logic [16:0] pages_avail;

  rsp_t expected_rsp_q[$];
  int   fails;
  int   checked;

  assign fail_count_o = fails;
  assign pending_o    = expected_rsp_q.size();
  assign checked_o    = checked;

  function automatic void write_block(int unsigned p, int unsigned len, bit used);
    int unsigned last;
    last = p + len - 1;
    blk_len[p] = len;
    page_used[p] = used;
    page_used[last] = used;
    blk_head[last] = p;
  endfunction

  function automatic void heap_setup();
    int unsigned n;
    n = (pages_reg > NPAGES) ? NPAGES : pages_reg;
    heap_base = (base_reg + 64'hFFF) & ~64'hFFF;
    heap_pages = n;
    for (int i = 0; i < NPAGES; i++) begin
      page_used[i] = 1'b0;
      alloc_head[i] = 1'b0;
    end
    pages_taken = '0;
    pages_avail = 17'(n);
    if (n > 0) write_block(0, n, 1'b0);
  endfunction

  function automatic status_e heap_take(logic [31:0] bytes, output logic [63:0] addr);
    longint unsigned need;
    int unsigned p, len, best_p, best_len;
    bit found;
    addr = '0;
    p = 0; best_p = 0; best_len = 0; found = 0;
    if (bytes == 0) return ST_NO_FIT;
    need = (longint'(bytes) + 4095) >> PG_LOG2;
    while (p < heap_pages) begin
      len = blk_len[p];
      if (len == 0 || longint'(p) + len > heap_pages) break;
      if (!page_used[p] && len >= need && (!found || len < best_len)) begin
        found = 1; best_p = p; best_len = len;
      end
      p += len;
    end
    if (!found) return ST_NO_FIT;
    write_block(best_p, int'(need), 1'b1);
    alloc_head[best_p] = 1'b1;
    if (best_len != need) write_block(best_p + int'(need), best_len - int'(need), 1'b0);
    pages_taken = pages_taken + 17'(need);
    pages_avail = pages_avail - 17'(need);
    addr = heap_base + (64'(best_p) << PG_LOG2);
    return ST_OK;
  endfunction

  function automatic status_e heap_release(logic [63:0] addr);
    logic [63:0] off, idx;
    int unsigned p, len, first, total, nxt;
    off = addr - heap_base;
    if (off[PG_LOG2-1:0] != 0) return ST_BAD_ADDR;
    idx = off >> PG_LOG2;
    if (idx >= heap_pages) return ST_BAD_ADDR;
    p = idx[31:0];
    if (!alloc_head[p]) return ST_BAD_ADDR;
    len = blk_len[p];
    if (len == 0 || longint'(p) + len > heap_pages) return ST_BAD_ADDR;
    alloc_head[p] = 1'b0;
    first = p;
    total = len;
    if (p > 0 && !page_used[p-1] && blk_head[p-1] < p) begin
      total += p - blk_head[p-1];
      first = blk_head[p-1];
    end
    nxt = p + len;
    if (nxt < heap_pages && !page_used[nxt] && longint'(nxt) + blk_len[nxt] <= heap_pages)
      total += blk_len[nxt];
    blk_len[p] = 0;
    write_block(first, total, 1'b0);
    pages_taken = pages_taken - 17'(len);
    pages_avail = pages_avail + 17'(len);
    return ST_OK;
  endfunction

  function automatic rsp_t heap_command(req_t r);
    rsp_t    o;
    status_e st;
    logic [63:0] a;
    st = ST_OK;
    a = '0;
    case (cmd_e'(r.command))
      CMD_INIT:  heap_setup();
      CMD_ALLOC: st = heap_take(r.request_bytes, a);
      CMD_FREE:  st = heap_release(r.block_address);
      default: ;
    endcase
    o.status = st;
    o.granted_address = (st == ST_OK) ? a : '0;
    o.heap_size_pages = 17'(heap_pages);
    o.allocated_pages = pages_taken;
    o.avail_pages = pages_avail;
    return o;
  endfunction

  initial begin
    base_reg = '0; pages_reg = '0; heap_base = '0; heap_pages = 0;
    pages_taken = '0; pages_avail = '0; fails = 0; checked = 0;
    for (int i = 0; i < NPAGES; i++) begin
      page_used[i] = 0; alloc_head[i] = 0; blk_len[i] = 0; blk_head[i] = 0;
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      // retire the result first: it always belongs to an earlier item
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %p", rsp_i);
        end else begin
          want = expected_rsp_q.pop_front();
          checked++;
          if (rsp_i.status !== want.status || rsp_i.granted_address !== want.granted_address
              || rsp_i.heap_size_pages !== want.heap_size_pages
              || rsp_i.allocated_pages !== want.allocated_pages
              || rsp_i.avail_pages !== want.avail_pages) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p got %p", want, rsp_i);
          end
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(heap_command(req_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[3] == REG_PAGES) pages_reg = pwdata_i[16:0];
        else base_reg = pwdata_i;
      end
    end
  end
endmodule

// File: tb/sv/tb_best_fit_page_allocator_unit.sv
`timescale 1ns / 100ps

module tb_best_fit_page_allocator_unit;
  import bfpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int fail_count, pending, checked;
  int items_sent;
  int stall_cycles;
  bit no_gaps;
  cmd_e        sent_cmd_q[$];
  logic [63:0] live_blocks[$];
  logic [63:0] freed_blocks[$];
  logic [63:0] cur_base;
  int unsigned cur_pages;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  best_fit_page_allocator_unit dut (
    .clk_i, .rst_ni, .start, .busy, .req_i(req), .done_o, .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  best_fit_page_allocator_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i(req), .done_i(done_o),
    .rsp_i(rsp_o), .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // track granted blocks so frees can hit real block starts
  always @(posedge clk_i) begin
    cmd_e c;
    if (rst_ni) begin
      if (done_o && sent_cmd_q.size() > 0) begin
        c = sent_cmd_q.pop_front();
        if (c == CMD_ALLOC && rsp_o.status == ST_OK) live_blocks.push_back(rsp_o.granted_address);
      end
      if (start && !busy) sent_cmd_q.push_back(cmd_e'(req.command));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_best_fit_page_allocator_unit NOT OK");
      $finish;
    end
  end

  task automatic issue(cmd_e c, logic [31:0] bytes, logic [63:0] addr);
    if (!no_gaps && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req <= '{command: c, request_bytes: bytes, block_address: addr};
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [0:0] idx, logic [63:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // reconfigure while idle, then rebuild the heap
  task automatic new_heap(logic [63:0] b, int unsigned n);
    drain();
    reg_write(REG_BASE, b);
    reg_write(REG_PAGES, 17'(n));
    cur_base = (b + 64'hFFF) & ~64'hFFF;
    cur_pages = n;
    live_blocks.delete();
    freed_blocks.delete();
    issue(CMD_INIT, $urandom, {$urandom, $urandom});
  endtask

  function automatic logic [31:0] pick_bytes();
    int unsigned r, maxp;
    r = $urandom_range(99);
    maxp = (cur_pages > 64) ? cur_pages / 8 : cur_pages + 1;
    if (r < 5) return $urandom;
    if (r < 8) return 32'd0;
    if (r < 12) return 32'(cur_pages) << 12;
    return (32'($urandom_range(1, maxp > 0 ? maxp : 1)) << 12) - 32'($urandom_range(0, 4095));
  endfunction

  task automatic random_items(int count);
    int unsigned r, k;
    logic [63:0] a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        drain();
      end
      r = $urandom_range(99);
      if (r < 45) begin
        issue(CMD_ALLOC, pick_bytes(), {$urandom, $urandom});
      end else if (r < 92) begin
        r = $urandom_range(99);
        if (r < 60 && live_blocks.size() > 0) begin
          drain();
          k = $urandom_range(live_blocks.size() - 1);
          a = live_blocks[k];
          live_blocks.delete(k);
          freed_blocks.push_back(a);
        end else if (r < 70 && freed_blocks.size() > 0) begin
          a = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
        end else if (r < 80 && live_blocks.size() > 0) begin
          a = live_blocks[$urandom_range(live_blocks.size() - 1)] + $urandom_range(1, 4095);
        end else if (r < 90) begin
          a = cur_base + (64'(cur_pages + $urandom_range(0, 3)) << 12);
        end else begin
          a = {$urandom, $urandom};
        end
        issue(CMD_FREE, $urandom, a);
      end else begin
        issue(CMD_REPORT, $urandom, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    logic [63:0] a0, a1, a2;
    items_sent = 0;
    no_gaps = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // heap not yet built
    issue(CMD_REPORT, '0, '0);
    issue(CMD_ALLOC, 32'd4096, '0);
    issue(CMD_FREE, '0, '0);

    new_heap(64'h0, 0);
    issue(CMD_ALLOC, 32'd1, '0);
    issue(CMD_FREE, '0, '0);

    // full-size heap whose base rounds up past the top of the address space to zero
    new_heap(64'hFFFF_FFFF_FFFF_F001, 65536);
    issue(CMD_ALLOC, 32'd0, '0);
    issue(CMD_ALLOC, 32'hFFFF_FFFF, '0);
    issue(CMD_ALLOC, 32'd1, '0);
    issue(CMD_ALLOC, 32'd4096, '0);
    issue(CMD_ALLOC, 32'd4097, '0);
    issue(CMD_ALLOC, 32'd8192, '0);
    drain();
    a0 = live_blocks[1]; a1 = live_blocks[2]; a2 = live_blocks[3];
    issue(CMD_FREE, '0, a0);
    issue(CMD_FREE, '0, a2);
    issue(CMD_FREE, '0, a1);
    issue(CMD_FREE, '0, a1);
    issue(CMD_FREE, '0, live_blocks[0] + 64'd1);
    issue(CMD_FREE, '0, cur_base + (64'd65536 << 12));
    issue(CMD_ALLOC, 32'h1000_0000 - 32'h4000, '0);
    issue(CMD_REPORT, '0, '0);
    live_blocks.delete();
    random_items(90);

    new_heap(64'h0, 1);
    issue(CMD_ALLOC, 32'd4096, '0);
    issue(CMD_ALLOC, 32'd1, '0);
    random_items(60);

    no_gaps = 1;
    new_heap({$urandom, $urandom}, 37);
    random_items(110);
    no_gaps = 0;

    new_heap({$urandom, $urandom}, 200);
    random_items(140);

    new_heap({$urandom, $urandom}, 12);
    random_items(140);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d commands over six heap setups, checked %0d results", items_sent, checked);
    $display("(unbuilt, empty, full-size wrapped, one-page and small heaps)");
    if (fail_count == 0) begin
      $display("tb_best_fit_page_allocator_unit OK");
    end else begin
      $display("tb_best_fit_page_allocator_unit NOT OK");
    end
    $finish;
  end
endmodule
